/* rtl/ctaus_pkg.sv */
package ctaus_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned CountWidth = 5;

  localparam logic [WordWidth-1:0] SeedValue = 32'd12345;
  localparam logic [WordWidth-1:0] MaskOne   = 32'd4294967294;
  localparam logic [WordWidth-1:0] MaskTwo   = 32'd4294967288;
  localparam logic [WordWidth-1:0] MaskThree = 32'd4294967280;
  localparam logic [WordWidth-1:0] MaskFour  = 32'd4294967168;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic write_out;
  } cmd_t;

  typedef struct packed {
    logic last_step;
  } status_t;

  function automatic logic [WordWidth-1:0] taus_advance(
    input logic [WordWidth-1:0] c,
    input int unsigned          s1,
    input int unsigned          s2,
    input logic [WordWidth-1:0] mask,
    input int unsigned          s3
  );
    logic [WordWidth-1:0] fb;
    fb = ((c << s1) ^ c) >> s2;
    return ((c & mask) << s3) ^ fb;
  endfunction

endpackage

/* rtl/ctaus_dp.sv */
module ctaus_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  ctaus_pkg::cmd_t                cmd,
  output ctaus_pkg::status_t             sts,
  input  logic [ctaus_pkg::WordWidth-1:0] range_limit,
  output logic [ctaus_pkg::WordWidth-1:0] random_value,
  output logic                           limit_zero_error
);

  logic [ctaus_pkg::WordWidth-1:0]  component_one;
  logic [ctaus_pkg::WordWidth-1:0]  component_two;
  logic [ctaus_pkg::WordWidth-1:0]  component_three;
  logic [ctaus_pkg::WordWidth-1:0]  component_four;
  logic [ctaus_pkg::WordWidth-1:0]  component_one_next;
  logic [ctaus_pkg::WordWidth-1:0]  component_two_next;
  logic [ctaus_pkg::WordWidth-1:0]  component_three_next;
  logic [ctaus_pkg::WordWidth-1:0]  component_four_next;
  logic [ctaus_pkg::WordWidth-1:0]  word_next;
  logic [ctaus_pkg::WordWidth-1:0]  divisor;
  logic [ctaus_pkg::WordWidth-1:0]  dividend;
  logic [ctaus_pkg::WordWidth-1:0]  rem;
  logic [ctaus_pkg::WordWidth:0]    trial;
  logic [ctaus_pkg::CountWidth-1:0] count;
  logic                             limit_zero;

  assign component_one_next   = ctaus_pkg::taus_advance(component_one, 6, 13,
                                  ctaus_pkg::MaskOne, 18);
  assign component_two_next   = ctaus_pkg::taus_advance(component_two, 2, 27,
                                  ctaus_pkg::MaskTwo, 2);
  assign component_three_next = ctaus_pkg::taus_advance(component_three, 13, 21,
                                  ctaus_pkg::MaskThree, 7);
  assign component_four_next  = ctaus_pkg::taus_advance(component_four, 3, 12,
                                  ctaus_pkg::MaskFour, 13);
  assign word_next = component_one_next ^ component_two_next
                   ^ component_three_next ^ component_four_next;

  assign trial = {rem, dividend[ctaus_pkg::WordWidth-1]} - {1'b0, divisor};
  assign sts.last_step = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      component_one   <= ctaus_pkg::SeedValue;
      component_two   <= ctaus_pkg::SeedValue;
      component_three <= ctaus_pkg::SeedValue;
      component_four  <= ctaus_pkg::SeedValue;
      count           <= '0;
    end else if (cmd.load) begin
      component_one   <= component_one_next;
      component_two   <= component_two_next;
      component_three <= component_three_next;
      component_four  <= component_four_next;
      count           <= '1;
    end else if (cmd.step) begin
      count <= count - 1'b1;
    end
  end

  // restoring division, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      divisor    <= range_limit;
      dividend   <= word_next;
      rem        <= '0;
      limit_zero <= (range_limit == '0);
    end else if (cmd.step) begin
      dividend <= {dividend[ctaus_pkg::WordWidth-2:0], 1'b0};
      if (trial[ctaus_pkg::WordWidth]) begin
        rem <= {rem[ctaus_pkg::WordWidth-2:0], dividend[ctaus_pkg::WordWidth-1]};
      end else begin
        rem <= trial[ctaus_pkg::WordWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_out) begin
      random_value     <= limit_zero ? '0 : rem;
      limit_zero_error <= limit_zero;
    end
  end

endmodule

/* rtl/ctaus_ctrl.sv */
module ctaus_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output ctaus_pkg::cmd_t    cmd,
  input  ctaus_pkg::status_t sts
);

  ctaus_pkg::state_t state;
  ctaus_pkg::state_t state_next;
  logic              out_full;
  logic              out_full_next;

  always_comb begin
    state_next = state;
    case (state)
      ctaus_pkg::ST_IDLE: begin
        if (in_valid) state_next = ctaus_pkg::ST_DIVIDE;
      end
      ctaus_pkg::ST_DIVIDE: begin
        if (sts.last_step) state_next = ctaus_pkg::ST_FINISH;
      end
      ctaus_pkg::ST_FINISH: begin
        if (!out_full || !out_stall) state_next = ctaus_pkg::ST_IDLE;
      end
      default: state_next = ctaus_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state != ctaus_pkg::ST_IDLE);
    cmd.load      = (state == ctaus_pkg::ST_IDLE) && in_valid;
    cmd.step      = (state == ctaus_pkg::ST_DIVIDE);
    cmd.write_out = (state == ctaus_pkg::ST_FINISH) && (!out_full || !out_stall);
  end

  always_comb begin
    out_full_next = out_full;
    if (cmd.write_out) begin
      out_full_next = 1'b1;
    end else if (out_full && !out_stall) begin
      out_full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ctaus_pkg::ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  assign out_valid = out_full;

  assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ctaus_pkg::ST_DIVIDE)
    else $error("load did not start division");

  assert property (@(posedge clk) disable iff (rst)
    (state == ctaus_pkg::ST_DIVIDE && sts.last_step) |=> state == ctaus_pkg::ST_FINISH)
    else $error("division did not finish on last step");

  assert property (@(posedge clk) disable iff (rst)
    cmd.write_out |=> out_valid)
    else $error("result written but not presented");

  assert property (@(posedge clk) disable iff (rst)
    (state == ctaus_pkg::ST_FINISH && out_full && out_stall) |=> state == ctaus_pkg::ST_FINISH)
    else $error("finished result dropped while output stalled");

endmodule

/* rtl/combined_tausworthe_random.sv */
// channel | signals                      | direction
// input   | in_valid, in_stall           | range_limit in
// output  | out_valid, out_stall         | random_value, limit_zero_error out
//
// In one draw, the accepting cycle advances the four components, then a
// radix-2 restoring divider runs 32 steps for the remainder, then the finish
// state loads the output register once that register is empty or not stalled.
// Reset (rst, synchronous) seeds all components with 12345 and empties the output.
// A stalled output holds the finished draw; the input is taken again once the
// divider hands its result to the output register.
module combined_tausworthe_random (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ctaus_pkg::WordWidth-1:0] range_limit,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ctaus_pkg::WordWidth-1:0] random_value,
  output logic                            limit_zero_error
);

  ctaus_pkg::cmd_t    cmd;
  ctaus_pkg::status_t sts;

  ctaus_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ctaus_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .range_limit      (range_limit),
    .random_value     (random_value),
    .limit_zero_error (limit_zero_error)
  );

endmodule

/* tb/tb_combined_tausworthe_random.sv */
module tb_combined_tausworthe_random;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W = ctaus_pkg::WordWidth;
  localparam logic [W-1:0] SEED       = 32'd12345;
  localparam logic [W-1:0] KEEP_ONE   = 32'hFFFF_FFFE;
  localparam logic [W-1:0] KEEP_TWO   = 32'hFFFF_FFF8;
  localparam logic [W-1:0] KEEP_THREE = 32'hFFFF_FFF0;
  localparam logic [W-1:0] KEEP_FOUR  = 32'hFFFF_FF80;

  localparam logic ERR_NONE       = 1'b0;
  localparam logic ERR_ZERO_LIMIT = 1'b1;

  localparam int RANDOM_DRAWS = 400;
  localparam int DRAIN_EVERY  = 150;
  localparam int LONG_HOLD_AT = 100;
  localparam int LONG_HOLD    = 500;
  localparam int DRAW_LATENCY = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int NUM_DIRECTED = 18;

  typedef struct {
    logic [W-1:0] limit;
    bit           typed;
    logic [W-1:0] value;
    logic         err;
  } limit_row_t;

  typedef struct {
    logic [W-1:0] value;
    logic         err;
  } draw_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic [W-1:0] range_limit = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [W-1:0] random_value;
  logic         limit_zero_error;

  logic [W-1:0] comp_one, comp_two, comp_three, comp_four;
  draw_t        expected_draws[$];
  int           failures = 0;
  int           cycle_count = 0;
  int           burst_left = 0;
  bit           long_hold_request = 1'b0;

  limit_row_t directed_rows [0:NUM_DIRECTED-1] = '{
    '{32'h0000_0000, 1'b1, 32'd0, ERR_ZERO_LIMIT},
    '{32'h0000_0001, 1'b1, 32'd0, ERR_NONE},
    '{32'hFFFF_FFFF, 1'b0, 32'd0, ERR_NONE},
    '{32'h8000_0000, 1'b0, 32'd0, ERR_NONE},
    '{32'h0000_0002, 1'b0, 32'd0, ERR_NONE},
    '{32'h0000_0003, 1'b0, 32'd0, ERR_NONE},
    '{32'hFFFF_FFFE, 1'b0, 32'd0, ERR_NONE},
    '{32'h7FFF_FFFF, 1'b0, 32'd0, ERR_NONE},
    '{32'h0000_0000, 1'b1, 32'd0, ERR_ZERO_LIMIT},
    '{32'h0000_0001, 1'b1, 32'd0, ERR_NONE},
    '{32'h5555_5555, 1'b0, 32'd0, ERR_NONE},
    '{32'hAAAA_AAAA, 1'b0, 32'd0, ERR_NONE},
    '{32'h0000_000A, 1'b0, 32'd0, ERR_NONE},
    '{32'h0000_FFFF, 1'b0, 32'd0, ERR_NONE},
    '{32'h0001_0000, 1'b0, 32'd0, ERR_NONE},
    '{32'hC000_0001, 1'b0, 32'd0, ERR_NONE},
    '{32'h0000_0000, 1'b1, 32'd0, ERR_ZERO_LIMIT},
    '{32'hDEAD_BEEF, 1'b0, 32'd0, ERR_NONE}
  };

  combined_tausworthe_random dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .range_limit      (range_limit),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .random_value     (random_value),
    .limit_zero_error (limit_zero_error)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [W-1:0] combined_word();
    logic [W-1:0] fb;
    fb         = ((comp_one << 6) ^ comp_one) >> 13;
    comp_one   = ((comp_one & KEEP_ONE) << 18) ^ fb;
    fb         = ((comp_two << 2) ^ comp_two) >> 27;
    comp_two   = ((comp_two & KEEP_TWO) << 2) ^ fb;
    fb         = ((comp_three << 13) ^ comp_three) >> 21;
    comp_three = ((comp_three & KEEP_THREE) << 7) ^ fb;
    fb         = ((comp_four << 3) ^ comp_four) >> 12;
    comp_four  = ((comp_four & KEEP_FOUR) << 13) ^ fb;
    return comp_one ^ comp_two ^ comp_three ^ comp_four;
  endfunction

  function automatic draw_t predict_draw(input logic [W-1:0] limit);
    draw_t        d;
    logic [W-1:0] word;
    word = combined_word();
    if (limit == '0) begin
      d.value = '0;
      d.err   = ERR_ZERO_LIMIT;
    end else begin
      d.value = word % limit;
      d.err   = ERR_NONE;
    end
    return d;
  endfunction

  function automatic logic [W-1:0] pick_limit();
    case ($urandom_range(15))
      0:       return '0;
      1:       return 32'd1;
      2, 3, 4: return W'($urandom_range(255, 2));
      5, 6:    return 32'd1 << $urandom_range(31);
      7:       return 32'hFFFF_FFFF - W'($urandom_range(15));
      default: return W'($urandom());
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(19);
    if (r <= 10) return 0;
    if (r <= 15) return $urandom_range(3, 1);
    if (r <= 17) return $urandom_range(50, 4);
    burst_left = $urandom_range(40, 10);
    return 0;
  endfunction

  // offer one limit and hold it until the transfer
  task automatic offer(input limit_row_t row);
    draw_t d;
    range_limit <= row.limit;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    d = predict_draw(row.limit);
    if (row.typed) begin
      d.value = row.value;
      d.err   = row.err;
    end
    expected_draws.push_back(d);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk);
  endtask

  task automatic idle_after_transfer();
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : receiver
    bit stall;
    int n;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_request) begin
        long_hold_request = 1'b0;
        stall = 1'b1;
        n     = LONG_HOLD;
      end else begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
            stall = 1'b0;
            n     = 1;
          end
          11, 12, 13, 14, 15: begin
            stall = 1'b1;
            n     = $urandom_range(3, 1);
          end
          16, 17: begin
            stall = 1'b1;
            n     = $urandom_range(40, 4);
          end
          default: begin
            stall = 1'b0;
            n     = $urandom_range(150, 20);
          end
        endcase
      end
      out_stall <= stall;
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    draw_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_draws.size() == 0) begin
        $error("unexpected transfer: random_value=%0h limit_zero_error=%0b",
               random_value, limit_zero_error);
        failures++;
      end else begin
        want = expected_draws.pop_front();
        if (random_value !== want.value) begin
          $error("random_value: expected %0h, got %0h", want.value, random_value);
          failures++;
        end
        if (limit_zero_error !== want.err) begin
          $error("limit_zero_error: expected %0b, got %0b", want.err, limit_zero_error);
          failures++;
        end
      end
    end
  end

  initial begin : sender
    limit_row_t row;
    comp_one   = SEED;
    comp_two   = SEED;
    comp_three = SEED;
    comp_four  = SEED;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      offer(directed_rows[i]);
      idle_after_transfer();
    end
    drain();

    for (int i = 0; i < RANDOM_DRAWS; i++) begin
      if (i == LONG_HOLD_AT) long_hold_request = 1'b1;
      row = '{pick_limit(), 1'b0, '0, ERR_NONE};
      offer(row);
      if (i % DRAIN_EVERY == DRAIN_EVERY - 1) drain();
      else idle_after_transfer();
    end

    drain();
    repeat (DRAW_LATENCY) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
